// File: hw/rtl/htw_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the hierarchical timer wheel.
// Depends on nothing; imported by the top level, htw_place and htw_checker.
package htw_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [2:0] RES_ADDED     = 3'd0;
    localparam logic [2:0] RES_EXPIRED   = 3'd1;
    localparam logic [2:0] RES_IMMEDIATE = 3'd2;
    localparam logic [2:0] RES_FULL      = 3'd3;
    localparam logic [2:0] RES_CANCEL    = 3'd4;
    localparam logic [2:0] RES_DONE      = 3'd5;

    localparam int NUM_LEVELS = 4;

    typedef enum logic [13:0] {
        ST_CLR   = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_CAN   = 14'b00000000000100,
        ST_PCALC = 14'b00000000001000,
        ST_PRD   = 14'b00000000010000,
        ST_PWR   = 14'b00000000100000,
        ST_FRD   = 14'b00000001000000,
        ST_FHD   = 14'b00000010000000,
        ST_FEMIT = 14'b00000100000000,
        ST_ADV   = 14'b00001000000000,
        ST_CRD   = 14'b00010000000000,
        ST_CHD   = 14'b00100000000000,
        ST_CNEXT = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } htw_state_t;

endpackage

// File: hw/rtl/hierarchical_timer_wheel.sv
`timescale 1ns / 1ps
// Top level of the hierarchical timer wheel: sequencer, entry pool and output register.
// Depends on htw_pkg, htw_ram and htw_place.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_req_type s_delay s_user_tag s_timer_handle
//  m_      | out       | m_valid m_ready m_result_kind m_handle m_tag m_last
//
// An immediate add or a full pool is answered straight from the idle state; a cancel passes through ST_CAN and a
// placed add through ST_PCALC, ST_PRD and ST_PWR. A tick drains the near bucket, advances time, places each entry
// of a coarse bucket anew when it cascades, and drains the new near bucket; the bucket RAM sets the pace.
// After reset a clearing pass over all NEAR_SIZE + 4 * LEVEL_SIZE buckets empties them.
// A stalled output word holds the sequencer at its next emit.
module hierarchical_timer_wheel #(
    parameter int NEAR_BITS    = 8,
    parameter int LEVEL_BITS   = 6,
    parameter int POOL_ENTRIES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_delay,
    input  logic [15:0]        s_user_tag,
    input  logic [4:0]         s_timer_handle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_result_kind,
    output logic [4:0]         m_handle,
    output logic [15:0]        m_tag,
    output logic               m_last
);
    import htw_pkg::*;

    localparam int NEAR_SIZE  = 1 << NEAR_BITS;
    localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
    localparam int DEPTH      = NEAR_SIZE + NUM_LEVELS * LEVEL_SIZE;
    localparam int AW         = $clog2(DEPTH);
    localparam int HW         = $clog2(POOL_ENTRIES);
    localparam int BW         = 1 + 2 * HW;

    htw_state_t state_reg, state_next;

    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [31:0]             wt_reg, wt_next;
    logic [POOL_ENTRIES-1:0] in_use_reg, in_use_next;
    logic [POOL_ENTRIES-1:0] canc_reg, canc_next;
    logic [HW-1:0]           cur_reg, cur_next;
    logic [HW-1:0]           tail_reg, tail_next;
    logic [HW-1:0]           nxt_reg, nxt_next;
    logic                    at_tail_reg, at_tail_next;
    logic                    ret_casc_reg, ret_casc_next;
    logic                    phase_reg, phase_next;
    logic                    can_ok_reg, can_ok_next;
    logic [4:0]              hnd_reg, hnd_next;
    logic [AW-1:0]           bkt_reg, bkt_next;
    logic [AW-1:0]           casc_reg, casc_next;

    logic [31:0] expiry_mem [POOL_ENTRIES];
    logic [15:0] tag_mem [POOL_ENTRIES];
    logic [HW-1:0] link_mem [POOL_ENTRIES];

    logic          exp_we, tag_we, link_cur_we, link_tail_we;
    logic [31:0]   exp_wdata;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_kind_reg, m_kind_next;
    logic [4:0]    m_handle_reg, m_handle_next;
    logic [15:0]   m_tag_reg, m_tag_next;
    logic          m_last_reg, m_last_next;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [BW-1:0] ram_wdata, ram_rdata;
    logic          rd_ne;
    logic [HW-1:0] rd_head, rd_tail;

    logic [AW-1:0] place_addr, near_addr;
    logic [31:0]   ct;
    logic [63:0]   ct64;
    logic          casc_hit, casc_go;
    logic [AW-1:0] casc_addr;
    logic [LEVEL_BITS-1:0] casc_fld;

    logic          free_found;
    logic [HW-1:0] free_idx;
    logic          accept;

    htw_ram #(.DEPTH(DEPTH), .WIDTH(BW), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htw_place #(.NEAR_BITS(NEAR_BITS), .LEVEL_BITS(LEVEL_BITS), .AW(AW)) u_place (
        .expiry (expiry_mem[cur_reg]),
        .wtime  (wt_reg),
        .addr   (place_addr)
    );

    assign {rd_ne, rd_head, rd_tail} = ram_rdata;
    assign near_addr = AW'(wt_reg[NEAR_BITS-1:0]);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_handle      = m_handle_reg;
    assign m_tag         = m_tag_reg;
    assign m_last        = m_last_reg;

    // Lowest free pool entry.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            if (!free_found && !in_use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = HW'(i);
            end
        end
    end

    // Which coarse bucket, if any, cascades when time advances to ct.
    assign ct   = wt_reg + 32'd1;
    assign ct64 = {32'd0, ct};
    always_comb begin
        casc_hit  = 1'b0;
        casc_addr = AW'(NEAR_SIZE + (NUM_LEVELS - 1) * LEVEL_SIZE);
        casc_go   = 1'b1;
        casc_fld  = '0;
        if (ct == 32'd0) begin
            casc_hit = 1'b1;
            casc_go  = 1'b0;
        end
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (casc_go) begin
                if ((ct64 & ((64'd1 << (NEAR_BITS + l * LEVEL_BITS)) - 64'd1)) == 64'd0) begin
                    casc_fld = LEVEL_BITS'(ct64 >> (NEAR_BITS + l * LEVEL_BITS));
                    if (casc_fld != '0) begin
                        casc_hit  = 1'b1;
                        casc_addr = AW'(NEAR_SIZE + l * LEVEL_SIZE) + AW'(casc_fld);
                        casc_go   = 1'b0;
                    end
                end else begin
                    casc_go = 1'b0;
                end
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        wt_next       = wt_reg;
        in_use_next   = in_use_reg;
        canc_next     = canc_reg;
        cur_next      = cur_reg;
        tail_next     = tail_reg;
        nxt_next      = nxt_reg;
        at_tail_next  = at_tail_reg;
        ret_casc_next = ret_casc_reg;
        phase_next    = phase_reg;
        can_ok_next   = can_ok_reg;
        hnd_next      = hnd_reg;
        bkt_next      = bkt_reg;
        casc_next     = casc_reg;
        exp_we        = 1'b0;
        tag_we        = 1'b0;
        link_cur_we   = 1'b0;
        link_tail_we  = 1'b0;
        exp_wdata     = s_delay + wt_reg;
        ram_we        = 1'b0;
        ram_waddr     = bkt_reg;
        ram_wdata     = '0;
        ram_raddr     = '0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_handle_next = m_handle_reg;
        m_tag_next    = m_tag_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_ADD: begin
                            m_valid_next = 1'b1;
                            m_tag_next   = s_user_tag;
                            m_last_next  = 1'b1;
                            m_handle_next = 5'd0;
                            if (s_delay[31] || s_delay == 32'sd0) begin
                                m_kind_next = RES_IMMEDIATE;
                            end else if (!free_found) begin
                                m_kind_next = RES_FULL;
                            end else begin
                                m_kind_next   = RES_ADDED;
                                m_handle_next = 5'(free_idx);
                                in_use_next[free_idx] = 1'b1;
                                canc_next[free_idx]   = 1'b0;
                                exp_we        = 1'b1;
                                tag_we        = 1'b1;
                                cur_next      = free_idx;
                                ret_casc_next = 1'b0;
                                state_next    = ST_PCALC;
                            end
                        end
                        REQ_CANCEL: begin
                            hnd_next    = s_timer_handle;
                            cur_next    = HW'(s_timer_handle);
                            can_ok_next = 1'b0;
                            if (32'(s_timer_handle) < 32'(POOL_ENTRIES)) begin
                                if (in_use_reg[HW'(s_timer_handle)]) begin
                                    can_ok_next = 1'b1;
                                    canc_next[HW'(s_timer_handle)] = 1'b1;
                                end
                            end
                            state_next = ST_CAN;
                        end
                        REQ_TICK: begin
                            phase_next = 1'b0;
                            state_next = ST_FRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CAN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = RES_CANCEL;
                    m_handle_next = hnd_reg;
                    m_tag_next    = can_ok_reg ? tag_mem[cur_reg] : 16'd0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PCALC: begin
                bkt_next   = place_addr;
                state_next = ST_PRD;
            end
            ST_PRD: begin
                ram_raddr  = bkt_reg;
                state_next = ST_PWR;
            end
            ST_PWR: begin
                // Append the entry at the tail of the bucket's list.
                ram_we       = 1'b1;
                ram_waddr    = bkt_reg;
                ram_wdata    = {1'b1, rd_ne ? rd_head : cur_reg, cur_reg};
                link_tail_we = rd_ne;
                link_cur_we  = 1'b1;
                if (!ret_casc_reg) begin
                    state_next = ST_IDLE;
                end else if (at_tail_reg) begin
                    state_next = ST_FRD;
                end else begin
                    cur_next   = nxt_reg;
                    state_next = ST_CNEXT;
                end
            end
            ST_FRD: begin
                ram_raddr  = near_addr;
                state_next = ST_FHD;
            end
            ST_FHD: begin
                ram_we    = 1'b1;
                ram_waddr = near_addr;
                if (rd_ne) begin
                    cur_next   = rd_head;
                    tail_next  = rd_tail;
                    state_next = ST_FEMIT;
                end else begin
                    state_next = phase_reg ? ST_DONE : ST_ADV;
                end
            end
            ST_FEMIT: begin
                if (canc_reg[cur_reg] || out_free) begin
                    if (!canc_reg[cur_reg]) begin
                        m_valid_next  = 1'b1;
                        m_kind_next   = RES_EXPIRED;
                        m_handle_next = 5'(cur_reg);
                        m_tag_next    = tag_mem[cur_reg];
                        m_last_next   = 1'b0;
                    end
                    canc_next[cur_reg]   = 1'b0;
                    in_use_next[cur_reg] = 1'b0;
                    if (cur_reg == tail_reg) begin
                        state_next = phase_reg ? ST_DONE : ST_ADV;
                    end else begin
                        cur_next = link_mem[cur_reg];
                    end
                end
            end
            ST_ADV: begin
                wt_next    = ct;
                phase_next = 1'b1;
                casc_next  = casc_addr;
                state_next = casc_hit ? ST_CRD : ST_FRD;
            end
            ST_CRD: begin
                ram_raddr  = casc_reg;
                state_next = ST_CHD;
            end
            ST_CHD: begin
                ram_we    = 1'b1;
                ram_waddr = casc_reg;
                if (rd_ne) begin
                    cur_next   = rd_head;
                    tail_next  = rd_tail;
                    state_next = ST_CNEXT;
                end else begin
                    state_next = ST_FRD;
                end
            end
            ST_CNEXT: begin
                // The link is saved first, since placing the entry rewrites it.
                nxt_next      = link_mem[cur_reg];
                at_tail_next  = (cur_reg == tail_reg);
                ret_casc_next = 1'b1;
                state_next    = ST_PCALC;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = RES_DONE;
                    m_handle_next = 5'd0;
                    m_tag_next    = 16'd0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_cnt_reg  <= '0;
            wt_reg       <= '0;
            in_use_reg   <= '0;
            canc_reg     <= '0;
            m_valid_reg  <= 1'b0;
            ret_casc_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            wt_reg       <= wt_next;
            in_use_reg   <= in_use_next;
            canc_reg     <= canc_next;
            m_valid_reg  <= m_valid_next;
            ret_casc_reg <= ret_casc_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        tail_reg     <= tail_next;
        nxt_reg      <= nxt_next;
        at_tail_reg  <= at_tail_next;
        can_ok_reg   <= can_ok_next;
        hnd_reg      <= hnd_next;
        bkt_reg      <= bkt_next;
        casc_reg     <= casc_next;
        m_kind_reg   <= m_kind_next;
        m_handle_reg <= m_handle_next;
        m_tag_reg    <= m_tag_next;
        m_last_reg   <= m_last_next;
        if (exp_we) begin
            expiry_mem[free_idx] <= exp_wdata;
        end
        if (tag_we) begin
            tag_mem[free_idx] <= s_user_tag;
        end
        if (link_tail_we) begin
            link_mem[rd_tail] <= cur_reg;
        end
        if (link_cur_we) begin
            link_mem[cur_reg] <= '0;
        end
    end
endmodule

// File: hw/rtl/htw_ram.sv
`timescale 1ns / 1ps
// Bucket list RAM: one write port and one read port with registered read data.
// Depends on nothing.
module htw_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 11,
    parameter int AW    = 9
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/htw_place.sv
`timescale 1ns / 1ps
// Bucket selection: maps an expiry time and the wheel time to a bucket address.
// Depends on htw_pkg.
module htw_place #(
    parameter int NEAR_BITS  = 8,
    parameter int LEVEL_BITS = 6,
    parameter int AW         = 9
) (
    input  logic [31:0]   expiry,
    input  logic [31:0]   wtime,
    output logic [AW-1:0] addr
);
    import htw_pkg::*;

    localparam int NEAR_SIZE  = 1 << NEAR_BITS;
    localparam int LEVEL_SIZE = 1 << LEVEL_BITS;

    logic [31:0]         span;
    logic [63:0]         dist64;
    logic [63:0]         t64;
    logic [LEVEL_BITS-1:0] idx;
    logic                found;

    assign span   = expiry - wtime;
    assign dist64 = {32'd0, span};
    assign t64    = {32'd0, expiry};

    always_comb begin
        found = 1'b0;
        idx   = '0;
        addr  = AW'(expiry[NEAR_BITS-1:0]);
        if (dist64 < 64'(NEAR_SIZE)) begin
            found = 1'b1;
        end
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (!found && (k == NUM_LEVELS - 1 ||
                           (dist64 >> (NEAR_BITS + (k + 1) * LEVEL_BITS)) == 64'd0)) begin
                found = 1'b1;
                idx   = LEVEL_BITS'(t64 >> (NEAR_BITS + k * LEVEL_BITS));
                addr  = AW'(NEAR_SIZE + k * LEVEL_SIZE) + AW'(idx);
            end
        end
    end
endmodule

// File: hw/rtl/htw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the hierarchical timer wheel, bound to the top level.
// Depends on htw_pkg and hierarchical_timer_wheel.
module htw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_result_kind,
    input logic [4:0]  m_handle,
    input logic [15:0] m_tag,
    input logic        m_last
);
    import htw_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_tag)
                                && $stable(m_handle) && $stable(m_last))
        else $error("stalled result word changed");

    // The done word closes a tick and carries no handle or tag.
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == RES_DONE |-> m_last && m_handle == 5'd0 && m_tag == 16'd0)
        else $error("malformed done word");

    // An expired word is never marked last; the done word closes the tick.
    a_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == RES_EXPIRED |-> !m_last)
        else $error("expired word marked last");

    // Every other word is the only one of its request.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == RES_ADDED || m_result_kind == RES_IMMEDIATE ||
                    m_result_kind == RES_FULL || m_result_kind == RES_CANCEL) |-> m_last)
        else $error("single word not marked last");
endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_handle      (m_handle),
    .m_tag         (m_tag),
    .m_last        (m_last)
);
